[sv/srs_pkg.sv]
package srs_pkg;

    // Design constants
    localparam int ATTEMPT_LIMIT    = 31;
    localparam int JITTER_FRAC_BITS = 8;

    // Field widths
    localparam int CFG_W = 16;
    localparam int IDX_W = 2;
    localparam int OP_W  = 4;
    localparam int JIT_W = 9;
    localparam int CMD_W = 3;
    localparam int SS_W  = 3;
    localparam int ATT_W = 5;
    localparam int TOT_W = 32;
    localparam int DLY_W = 17;
    localparam int STG_W = 17;
    localparam int SIL_W = 18;

    // Jitter datapath: wide enough for the raw field and for three halves of one.
    localparam int JW     = (JITTER_FRAC_BITS + 1 > JIT_W) ? JITTER_FRAC_BITS + 1 : JIT_W;
    localparam int PROD_W = CFG_W + JW;

    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 4'd0,
        OP_START      = 4'd1,
        OP_STOP       = 4'd2,
        OP_OPENED     = 4'd3,
        OP_AUTH_REPLY = 4'd4,
        OP_SUBS_REPLY = 4'd5,
        OP_LOST       = 4'd6,
        OP_MESSAGE    = 4'd7,
        OP_SEND_FAIL  = 4'd8,
        OP_PROTO_ERR  = 4'd9
    } op_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE    = 3'd0,
        CMD_CONNECT = 3'd1,
        CMD_ABORT   = 3'd2,
        CMD_AUTH    = 3'd3,
        CMD_SUBS    = 3'd4,
        CMD_LIVE    = 3'd5
    } cmd_t;

    typedef enum logic [SS_W-1:0] {
        SS_DISC  = 3'd0,
        SS_CONN  = 3'd1,
        SS_AUTH  = 3'd2,
        SS_SUBS  = 3'd3,
        SS_LIVE  = 3'd4,
        SS_BACK  = 3'd5,
        SS_FATAL = 3'd6
    } sess_t;

    typedef enum logic [6:0] {
        PH_DISC  = 7'b0000001,
        PH_CONN  = 7'b0000010,
        PH_AUTH  = 7'b0000100,
        PH_SUBS  = 7'b0001000,
        PH_LIVE  = 7'b0010000,
        PH_BACK  = 7'b0100000,
        PH_FATAL = 7'b1000000
    } phase_t;

    typedef enum logic [IDX_W-1:0] {
        CFG_BASE      = 2'd0,
        CFG_MAX       = 2'd1,
        CFG_TIMEOUT   = 2'd2,
        CFG_HEARTBEAT = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic             success;
        logic [JIT_W-1:0] jitter_scale;
    } evt_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [SS_W-1:0]  session_state;
        logic             error_raised;
        logic [ATT_W-1:0] attempt_count;
        logic [TOT_W-1:0] reconnect_total;
        logic [DLY_W-1:0] delay_ticks;
    } res_t;

    // Encode the one-hot phase as the reported session state.
    function automatic logic [SS_W-1:0] phase_code(phase_t p);
        logic [SS_W-1:0] c;
        case (p)
            PH_DISC:  c = SS_DISC;
            PH_CONN:  c = SS_CONN;
            PH_AUTH:  c = SS_AUTH;
            PH_SUBS:  c = SS_SUBS;
            PH_LIVE:  c = SS_LIVE;
            PH_BACK:  c = SS_BACK;
            PH_FATAL: c = SS_FATAL;
            default:  c = SS_DISC;
        endcase
        return c;
    endfunction

endpackage

[sv/srs_if.sv]
// Event channel into the supervisor.
interface srs_evt_if;
    logic                       valid;
    logic                       ready;
    logic [srs_pkg::OP_W-1:0]   operation;
    logic                       success;
    logic [srs_pkg::JIT_W-1:0]  jitter_scale;

    modport source (output valid, output operation, output success, output jitter_scale,
                    input ready);
    modport sink   (input valid, input operation, input success, input jitter_scale,
                    output ready);
endinterface

// Result channel out of the supervisor.
interface srs_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [srs_pkg::CMD_W-1:0]  command;
    logic [srs_pkg::SS_W-1:0]   session_state;
    logic                       error_raised;
    logic [srs_pkg::ATT_W-1:0]  attempt_count;
    logic [srs_pkg::TOT_W-1:0]  reconnect_total;
    logic [srs_pkg::DLY_W-1:0]  delay_ticks;

    modport source (output valid, output command, output session_state, output error_raised,
                    output attempt_count, output reconnect_total, output delay_ticks,
                    input ready);
    modport sink   (input valid, input command, input session_state, input error_raised,
                    input attempt_count, input reconnect_total, input delay_ticks,
                    output ready);
endinterface

[sv/session_reconnect_supervisor_top.sv]
// An accepted item waits in the input register, where the session step works on it, and its
// result is captured in the result register and offered on rsp; while rsp stalls, it stays put.
// Throughput: one item per cycle while rsp takes each result; the whole session step is one
// pass of logic between the input register and the result register.
// Reset: rst_n is asynchronous, active low; it clears the session state, restores
// the default configuration and empties both registers.
module session_reconnect_supervisor_top
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [srs_pkg::IDX_W-1:0]  cfg_index,
    input  logic [srs_pkg::CFG_W-1:0]  cfg_data,
    srs_evt_if.sink                    evt,
    srs_rsp_if.source                  rsp
);

    logic            in_valid_reg;
    srs_pkg::evt_t   in_item_reg;
    logic            out_valid_reg;
    srs_pkg::res_t   out_item_reg;
    srs_pkg::res_t   step_res;
    logic            advance;

    // The input register moves on whenever the result register can take its item.
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign evt.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (evt.ready)
        begin
            in_valid_reg <= evt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
        begin
            in_item_reg.operation    <= evt.operation;
            in_item_reg.success      <= evt.success;
            in_item_reg.jitter_scale <= evt.jitter_scale;
        end
    end

    // Session step.
    srs_fsm u_fsm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (advance),
        .evt       (in_item_reg),
        .res       (step_res)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= step_res;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.command         = out_item_reg.command;
    assign rsp.session_state   = out_item_reg.session_state;
    assign rsp.error_raised    = out_item_reg.error_raised;
    assign rsp.attempt_count   = out_item_reg.attempt_count;
    assign rsp.reconnect_total = out_item_reg.reconnect_total;
    assign rsp.delay_ticks     = out_item_reg.delay_ticks;

    // A chosen delay always comes with an abort and the backoff state.
    a_delay_in_backoff: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.delay_ticks != '0)
        |-> (rsp.command == srs_pkg::CMD_ABORT && rsp.session_state == srs_pkg::SS_BACK))
        else $error("delay reported outside backoff entry");

    // Going live clears the attempt count.
    a_live_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.command == srs_pkg::CMD_LIVE)
        |-> (rsp.attempt_count == '0 && rsp.session_state == srs_pkg::SS_LIVE))
        else $error("live announced with attempts pending");

    // A held input item stays in the input register until it can advance.
    a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("input item lost while stalled");

endmodule

[sv/srs_backoff.sv]
module srs_backoff
(
    input  logic [srs_pkg::CFG_W-1:0] base_delay,
    input  logic [srs_pkg::CFG_W-1:0] max_delay,
    input  logic [srs_pkg::ATT_W-1:0] attempts,
    input  logic [srs_pkg::JIT_W-1:0] jitter_scale,
    output logic [srs_pkg::DLY_W-1:0] delay
);

    localparam int SH_W = 2 * srs_pkg::CFG_W;
    localparam int SH_BITS = $clog2(srs_pkg::CFG_W);
    localparam logic [srs_pkg::JW-1:0] J_LO = srs_pkg::JW'(1) << (srs_pkg::JITTER_FRAC_BITS - 1);
    localparam logic [srs_pkg::JW-1:0] J_HI = srs_pkg::JW'(3) << (srs_pkg::JITTER_FRAC_BITS - 1);
    localparam int Q_W = srs_pkg::PROD_W - srs_pkg::JITTER_FRAC_BITS;

    logic [SH_W-1:0]           shifted;
    logic [srs_pkg::CFG_W-1:0] raw;
    logic [srs_pkg::JW-1:0]    j_in;
    logic [srs_pkg::JW-1:0]    j;
    logic [srs_pkg::PROD_W-1:0] prod;
    logic [Q_W-1:0]            quot;

    // Doubled base delay, capped. Any nonzero base shifted by a full register
    // width or more already exceeds every cap.
    always_comb
    begin
        shifted = {{(SH_W - srs_pkg::CFG_W){1'b0}}, base_delay} << attempts[SH_BITS-1:0];
        if (base_delay == '0)
        begin
            raw = '0;
        end
        else if (attempts >= srs_pkg::ATT_W'(srs_pkg::CFG_W))
        begin
            raw = max_delay;
        end
        else if (shifted > {{(SH_W - srs_pkg::CFG_W){1'b0}}, max_delay})
        begin
            raw = max_delay;
        end
        else
        begin
            raw = shifted[srs_pkg::CFG_W-1:0];
        end
    end

    // Clamp the jitter fraction to one half through three halves.
    always_comb
    begin
        j_in = srs_pkg::JW'(jitter_scale);
        if (j_in < J_LO)
        begin
            j = J_LO;
        end
        else if (j_in > J_HI)
        begin
            j = J_HI;
        end
        else
        begin
            j = j_in;
        end
    end

    // Scale by the jitter and drop the fraction bits, saturating to the field.
    always_comb
    begin
        prod = srs_pkg::PROD_W'(raw) * srs_pkg::PROD_W'(j);
        quot = prod[srs_pkg::PROD_W-1:srs_pkg::JITTER_FRAC_BITS];
        if (quot > Q_W'({srs_pkg::DLY_W{1'b1}}))
        begin
            delay = '1;
        end
        else
        begin
            delay = quot[srs_pkg::DLY_W-1:0];
        end
    end

endmodule

[sv/srs_fsm.sv]
module srs_fsm
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [srs_pkg::IDX_W-1:0]  cfg_index,
    input  logic [srs_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       step,
    input  srs_pkg::evt_t              evt,
    output srs_pkg::res_t              res
);

    logic [srs_pkg::CFG_W-1:0] base_delay_reg;
    logic [srs_pkg::CFG_W-1:0] max_delay_reg;
    logic [srs_pkg::CFG_W-1:0] timeout_reg;
    logic [srs_pkg::CFG_W-1:0] heartbeat_reg;

    srs_pkg::phase_t           phase_reg, phase_next;
    logic                      running_reg, running_next;
    logic [srs_pkg::ATT_W-1:0] attempts_reg, attempts_next;
    logic [srs_pkg::DLY_W-1:0] backoff_reg, backoff_next;
    logic [srs_pkg::STG_W-1:0] stage_reg, stage_next;
    logic [srs_pkg::SIL_W-1:0] silence_reg, silence_next;
    logic [srs_pkg::TOT_W-1:0] reconnects_reg, reconnects_next;

    logic [srs_pkg::DLY_W-1:0] bo_delay;
    logic [srs_pkg::DLY_W-1:0] delay_out;
    logic [srs_pkg::STG_W-1:0] stage_inc;
    logic [srs_pkg::SIL_W-1:0] silence_inc;
    logic [srs_pkg::SIL_W-1:0] hb3;
    logic [srs_pkg::DLY_W-1:0] remain_dec;
    logic                      in_hs;
    logic                      enter_bo;
    logic                      err;
    srs_pkg::cmd_t             cmd;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_delay_reg <= srs_pkg::CFG_W'(1);
            max_delay_reg  <= srs_pkg::CFG_W'(60);
            timeout_reg    <= srs_pkg::CFG_W'(10);
            heartbeat_reg  <= srs_pkg::CFG_W'(30);
        end
        else if (cfg_we)
        begin
            case (srs_pkg::cfg_idx_t'(cfg_index))
                srs_pkg::CFG_BASE:      base_delay_reg <= cfg_data;
                srs_pkg::CFG_MAX:       max_delay_reg  <= cfg_data;
                srs_pkg::CFG_TIMEOUT:   timeout_reg    <= cfg_data;
                srs_pkg::CFG_HEARTBEAT: heartbeat_reg  <= cfg_data;
                default:                base_delay_reg <= base_delay_reg;
            endcase
        end
    end

    // Backoff delay for the current attempt count and jitter.
    srs_backoff u_backoff
    (
        .base_delay   (base_delay_reg),
        .max_delay    (max_delay_reg),
        .attempts     (attempts_reg),
        .jitter_scale (evt.jitter_scale),
        .delay        (bo_delay)
    );

    // Saturating counters and the silence limit of three heartbeat periods.
    always_comb
    begin
        stage_inc   = (stage_reg != '1) ? stage_reg + 1'b1 : stage_reg;
        silence_inc = (silence_reg != '1) ? silence_reg + 1'b1 : silence_reg;
        remain_dec  = (backoff_reg != '0) ? backoff_reg - 1'b1 : backoff_reg;
        hb3 = (srs_pkg::SIL_W'(heartbeat_reg) << 1) + srs_pkg::SIL_W'(heartbeat_reg);
        in_hs = (phase_reg == srs_pkg::PH_CONN) || (phase_reg == srs_pkg::PH_AUTH)
             || (phase_reg == srs_pkg::PH_SUBS);
    end

    // Next state for one event.
    always_comb
    begin
        phase_next      = phase_reg;
        running_next    = running_reg;
        attempts_next   = attempts_reg;
        backoff_next    = backoff_reg;
        stage_next      = stage_reg;
        silence_next    = silence_reg;
        reconnects_next = reconnects_reg;
        cmd             = srs_pkg::CMD_NONE;
        err             = 1'b0;
        enter_bo        = 1'b0;
        delay_out       = '0;

        if (step)
        begin
            case (srs_pkg::op_t'(evt.operation))
                srs_pkg::OP_TICK:
                begin
                    if (running_reg && phase_reg != srs_pkg::PH_FATAL)
                    begin
                        if (phase_reg == srs_pkg::PH_BACK)
                        begin
                            backoff_next = remain_dec;
                            if (remain_dec == '0)
                            begin
                                phase_next   = srs_pkg::PH_CONN;
                                stage_next   = '0;
                                silence_next = '0;
                                cmd          = srs_pkg::CMD_CONNECT;
                            end
                        end
                        else if (in_hs)
                        begin
                            silence_next = silence_inc;
                            stage_next   = stage_inc;
                            enter_bo     = stage_inc > srs_pkg::STG_W'(timeout_reg);
                        end
                        else if (phase_reg == srs_pkg::PH_LIVE)
                        begin
                            silence_next = silence_inc;
                            enter_bo     = silence_inc > hb3;
                        end
                    end
                end
                srs_pkg::OP_START:
                begin
                    running_next  = 1'b1;
                    attempts_next = '0;
                    phase_next    = srs_pkg::PH_CONN;
                    stage_next    = '0;
                    silence_next  = '0;
                    cmd           = srs_pkg::CMD_CONNECT;
                end
                srs_pkg::OP_STOP:
                begin
                    running_next = 1'b0;
                    phase_next   = srs_pkg::PH_DISC;
                    cmd          = srs_pkg::CMD_ABORT;
                end
                srs_pkg::OP_OPENED:
                begin
                    if (phase_reg == srs_pkg::PH_CONN)
                    begin
                        phase_next = srs_pkg::PH_AUTH;
                        stage_next = '0;
                        cmd        = srs_pkg::CMD_AUTH;
                    end
                end
                srs_pkg::OP_AUTH_REPLY:
                begin
                    silence_next = '0;
                    if (phase_reg == srs_pkg::PH_AUTH)
                    begin
                        if (evt.success)
                        begin
                            phase_next = srs_pkg::PH_SUBS;
                            stage_next = '0;
                            cmd        = srs_pkg::CMD_SUBS;
                        end
                        else
                        begin
                            err        = 1'b1;
                            phase_next = srs_pkg::PH_FATAL;
                            cmd        = srs_pkg::CMD_ABORT;
                        end
                    end
                end
                srs_pkg::OP_SUBS_REPLY:
                begin
                    silence_next = '0;
                    if (phase_reg == srs_pkg::PH_SUBS)
                    begin
                        if (evt.success)
                        begin
                            phase_next    = srs_pkg::PH_LIVE;
                            attempts_next = '0;
                            cmd           = srs_pkg::CMD_LIVE;
                        end
                        else
                        begin
                            err      = 1'b1;
                            enter_bo = 1'b1;
                        end
                    end
                end
                srs_pkg::OP_LOST:
                begin
                    enter_bo = in_hs || (phase_reg == srs_pkg::PH_LIVE);
                end
                srs_pkg::OP_MESSAGE:
                begin
                    silence_next = '0;
                end
                srs_pkg::OP_SEND_FAIL:
                begin
                    if (phase_reg == srs_pkg::PH_AUTH || phase_reg == srs_pkg::PH_SUBS)
                    begin
                        err      = 1'b1;
                        enter_bo = 1'b1;
                    end
                end
                srs_pkg::OP_PROTO_ERR:
                begin
                    if (phase_reg == srs_pkg::PH_AUTH || phase_reg == srs_pkg::PH_SUBS
                        || phase_reg == srs_pkg::PH_LIVE)
                    begin
                        err      = 1'b1;
                        enter_bo = 1'b1;
                    end
                end
                default:
                begin
                    cmd = srs_pkg::CMD_NONE;
                end
            endcase

            // Entering backoff: a stopped session simply parks as disconnected.
            if (enter_bo)
            begin
                if (!running_reg)
                begin
                    phase_next = srs_pkg::PH_DISC;
                    cmd        = srs_pkg::CMD_NONE;
                end
                else
                begin
                    reconnects_next = reconnects_reg + 1'b1;
                    attempts_next   = (attempts_reg < srs_pkg::ATT_W'(srs_pkg::ATTEMPT_LIMIT))
                                    ? attempts_reg + 1'b1
                                    : srs_pkg::ATT_W'(srs_pkg::ATTEMPT_LIMIT);
                    backoff_next    = bo_delay;
                    delay_out       = bo_delay;
                    phase_next      = srs_pkg::PH_BACK;
                    cmd             = srs_pkg::CMD_ABORT;
                end
            end
        end
    end

    // Session state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= srs_pkg::PH_DISC;
            running_reg    <= 1'b0;
            attempts_reg   <= '0;
            backoff_reg    <= '0;
            stage_reg      <= '0;
            silence_reg    <= '0;
            reconnects_reg <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            running_reg    <= running_next;
            attempts_reg   <= attempts_next;
            backoff_reg    <= backoff_next;
            stage_reg      <= stage_next;
            silence_reg    <= silence_next;
            reconnects_reg <= reconnects_next;
        end
    end

    // Result of this event.
    always_comb
    begin
        res.command         = cmd;
        res.session_state   = srs_pkg::phase_code(phase_next);
        res.error_raised    = err;
        res.attempt_count   = attempts_next;
        res.reconnect_total = reconnects_next;
        res.delay_ticks     = delay_out;
    end

    // The attempt count never passes its limit.
    a_attempt_limit: assert property (@(posedge clk) disable iff (!rst_n)
        attempts_reg <= srs_pkg::ATT_W'(srs_pkg::ATTEMPT_LIMIT))
        else $error("attempt count above limit");

    // The reconnect total moves by at most one per cycle.
    a_reconnect_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (reconnects_reg == $past(reconnects_reg))
              || (reconnects_reg == $past(reconnects_reg) + srs_pkg::TOT_W'(1)))
        else $error("reconnect total jumped");

    // Only start or stop leaves the fatal phase.
    a_fatal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == srs_pkg::PH_FATAL
         && !(step && (evt.operation == srs_pkg::OP_START
                       || evt.operation == srs_pkg::OP_STOP)))
        |=> phase_reg == srs_pkg::PH_FATAL)
        else $error("fatal phase left without start or stop");

endmodule
